// ===== hdl/tlb_pkg.sv =====
// shared types and constants for the toroidal life board
// no dependencies; imported by every module of the block but tlb_ram
`timescale 1ns / 1ps

package tlb_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int RESET_DIM  = 64;

  localparam int XY_W   = 6;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int K_W    = $clog2(XY_W);
  localparam int ADDR_W = ROW_W + 1;
  localparam int RAM_DEPTH = 2 ** ADDR_W;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_WRITE = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_STEP  = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [MAX_WIDTH-1:0] row_t;

  typedef enum logic [1:0] {
    ROW_UP  = 2'd0,
    ROW_MID = 2'd1,
    ROW_DN  = 2'd2
  } row_tag_t;

  typedef struct packed {
    logic [DIM_W-1:0] board_width;
    logic [DIM_W-1:0] board_height;
  } cfg_t;

  typedef struct packed {
    logic             take_item;
    logic             reduce;
    logic [K_W-1:0]   reduce_k;
    logic             rd_en;
    row_tag_t         rd_tag;
    logic             use_sweep;
    logic [ROW_W-1:0] sweep_row;
    logic             wr_step;
    logic             set_cell;
    logic             flip_bank;
    logic             load_result;
  } dp_cmd_t;

  typedef struct packed {
    logic is_write;
    logic is_step;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== hdl/tlb_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module tlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tlb_cfg.sv =====
// apb register file holding board width and height, clamped on write
// depends on tlb_pkg
`timescale 1ns / 1ps

module tlb_cfg
  import tlb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [31:0] v, input logic [31:0] hi);
    logic [DIM_W-1:0] r;
    if (v < 32'd2) begin
      r = DIM_W'(2);
    end else if (v > hi) begin
      r = hi[DIM_W-1:0];
    end else begin
      r = v[DIM_W-1:0];
    end
    return r;
  endfunction

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.board_width  <= clamp_dim(32'(RESET_DIM), 32'(MAX_WIDTH));
      cfg.board_height <= clamp_dim(32'(RESET_DIM), 32'(MAX_HEIGHT));
    end else if (wr_hit) begin
      unique case (paddr[2])
        REG_WIDTH:  cfg.board_width  <= clamp_dim(pwdata, 32'(MAX_WIDTH));
        REG_HEIGHT: cfg.board_height <= clamp_dim(pwdata, 32'(MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = 32'(cfg.board_width);
      REG_HEIGHT: prdata = 32'(cfg.board_height);
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== hdl/tlb_ctrl.sv =====
// controller: sequences coordinate reduction, row loads, sweep and result
// depends on tlb_pkg
`timescale 1ns / 1ps

module tlb_ctrl
  import tlb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_REDUCE   = 6'b000010,
    S_LOAD     = 6'b000100,
    S_SWEEP_WR = 6'b001000,
    S_SET      = 6'b010000,
    S_FINISH   = 6'b100000
  } state_t;

  localparam logic [1:0] PHASE_WAIT = 2'd3;

  state_t           state, state_next;
  logic [K_W-1:0]   k_cnt, k_cnt_next;
  logic [1:0]       phase, phase_next;
  logic [ROW_W-1:0] row_cnt, row_cnt_next;
  logic             sweeping, sweeping_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      k_cnt    <= '0;
      phase    <= '0;
      row_cnt  <= '0;
      sweeping <= 1'b0;
    end else begin
      state    <= state_next;
      k_cnt    <= k_cnt_next;
      phase    <= phase_next;
      row_cnt  <= row_cnt_next;
      sweeping <= sweeping_next;
    end
  end

  always_comb begin
    state_next    = state;
    k_cnt_next    = k_cnt;
    phase_next    = phase;
    row_cnt_next  = row_cnt;
    sweeping_next = sweeping;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.reduce_k  = k_cnt;
    cmd.sweep_row = row_cnt;
    cmd.use_sweep = sweeping;
    case (phase)
      2'd0:    cmd.rd_tag = ROW_UP;
      2'd1:    cmd.rd_tag = ROW_MID;
      default: cmd.rd_tag = ROW_DN;
    endcase

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          k_cnt_next    = K_W'(XY_W - 1);
          state_next    = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.reduce = 1'b1;
        if (k_cnt == '0) begin
          phase_next = '0;
          if (stat.is_step) begin
            sweeping_next = 1'b1;
            row_cnt_next  = '0;
          end
          state_next = S_LOAD;
        end else begin
          k_cnt_next = k_cnt - 1'b1;
        end
      end
      S_LOAD: begin
        if (phase != PHASE_WAIT) begin
          cmd.rd_en  = 1'b1;
          phase_next = phase + 1'b1;
        end else if (sweeping) begin
          state_next = S_SWEEP_WR;
        end else if (stat.is_write) begin
          state_next = S_SET;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SWEEP_WR: begin
        cmd.wr_step = 1'b1;
        phase_next  = '0;
        state_next  = S_LOAD;
        if (row_cnt == ROW_LAST) begin
          cmd.flip_bank = 1'b1;
          sweeping_next = 1'b0;
        end else begin
          row_cnt_next = row_cnt + 1'b1;
        end
      end
      S_SET: begin
        cmd.set_cell = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/tlb_datapath.sv =====
// datapath: coordinate reduction, row registers, life lanes, banks, result
// depends on tlb_pkg and tlb_ram
`timescale 1ns / 1ps

module tlb_datapath
  import tlb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  cmd_t            in_command,
  input  logic [XY_W-1:0] in_x,
  input  logic [XY_W-1:0] in_y,
  input  logic            in_value,
  input  cfg_t            cfg,
  input  dp_cmd_t         cmd,
  output dp_stat_t        stat,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_cell_now,
  output logic            out_cell_next
);

  localparam int DIV_W = XY_W + DIM_W;

  // latched item
  cmd_t            cmd_q;
  logic [XY_W-1:0] x_rem, y_rem;
  logic            val_q;

  logic             active_q;
  logic [RAM_DEPTH-1:0] row_valid;
  row_t             up_q, mid_q, dn_q;
  logic             rd_pend;
  row_tag_t         rd_tag_q;
  logic             rd_ok_q;

  logic [DIV_W-1:0] x_div, y_div;
  logic [COL_W-1:0] x_col, w_last;
  logic [ROW_W-1:0] cur_row, up_row, dn_row, rd_row;
  logic [ADDR_W-1:0] raddr, waddr;
  logic             we;
  row_t             wdata, rdata, rd_eff, set_row, step_row, life;
  logic             row_in_h;

  assign x_div   = DIV_W'(cfg.board_width)  << cmd.reduce_k;
  assign y_div   = DIV_W'(cfg.board_height) << cmd.reduce_k;
  assign x_col   = COL_W'(x_rem);
  assign w_last  = COL_W'(cfg.board_width - DIM_W'(1));
  assign cur_row = cmd.use_sweep ? cmd.sweep_row : ROW_W'(y_rem);
  assign up_row  = (cur_row == '0) ? ROW_W'(cfg.board_height - DIM_W'(1)) : cur_row - 1'b1;
  assign dn_row  = ((DIM_W'(cur_row) + DIM_W'(1)) >= cfg.board_height) ? '0 : cur_row + 1'b1;
  assign row_in_h = DIM_W'(cmd.sweep_row) < cfg.board_height;

  always_comb begin
    case (cmd.rd_tag)
      ROW_UP:  rd_row = up_row;
      ROW_DN:  rd_row = dn_row;
      default: rd_row = cur_row;
    endcase
  end

  assign raddr  = {active_q, rd_row};
  assign rd_eff = rd_ok_q ? rdata : '0;

  always_comb begin
    set_row        = mid_q;
    set_row[x_col] = val_q;
  end

  // one life lane per column, wrapping at the configured width
  for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
    logic [COL_W-1:0] lc, rc;
    logic [3:0]       cnt;
    assign lc  = (c == 0) ? w_last : COL_W'(c - 1);
    assign rc  = (DIM_W'(c + 1) >= cfg.board_width) ? '0 : COL_W'(c + 1);
    assign cnt = {3'b0, up_q[lc]} + {3'b0, up_q[c]} + {3'b0, up_q[rc]}
               + {3'b0, mid_q[lc]} + {3'b0, mid_q[rc]}
               + {3'b0, dn_q[lc]} + {3'b0, dn_q[c]} + {3'b0, dn_q[rc]};
    assign life[c] = (cnt == 4'd3) || ((cnt == 4'd2) && mid_q[c]);
    // cells outside the area in use are carried over unchanged
    assign step_row[c] = (row_in_h && (DIM_W'(c) < cfg.board_width)) ? life[c] : mid_q[c];
  end

  assign we    = cmd.wr_step || cmd.set_cell;
  assign waddr = cmd.wr_step ? {~active_q, cmd.sweep_row} : {active_q, cur_row};
  assign wdata = cmd.wr_step ? step_row : set_row;

  tlb_ram #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active_q  <= 1'b0;
      row_valid <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en;
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      if (cmd.flip_bank) begin
        active_q <= ~active_q;
      end
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_tag_q <= cmd.rd_tag;
    rd_ok_q  <= row_valid[raddr];
    if (cmd.take_item) begin
      cmd_q <= in_command;
      x_rem <= in_x;
      y_rem <= in_y;
      val_q <= in_value;
    end else if (cmd.reduce) begin
      // one restoring step of x mod width and y mod height
      if (DIV_W'(x_rem) >= x_div) begin
        x_rem <= x_rem - x_div[XY_W-1:0];
      end
      if (DIV_W'(y_rem) >= y_div) begin
        y_rem <= y_rem - y_div[XY_W-1:0];
      end
    end
    if (rd_pend) begin
      case (rd_tag_q)
        ROW_UP:  up_q  <= rd_eff;
        ROW_DN:  dn_q  <= rd_eff;
        default: mid_q <= rd_eff;
      endcase
    end else if (cmd.set_cell) begin
      mid_q <= set_row;
    end
    if (cmd.load_result) begin
      out_cell_now  <= mid_q[x_col];
      out_cell_next <= life[x_col];
    end
  end

  assign stat.is_write = (cmd_q == CMD_WRITE);
  assign stat.is_step  = (cmd_q == CMD_STEP);
  assign stat.out_busy = out_valid && !out_ready;

endmodule

// ===== hdl/toroidal_life_board_core.sv =====
// top level of the toroidal life board: stream ports, apb registers
// depends on tlb_pkg, tlb_cfg, tlb_ctrl, tlb_datapath (and tlb_ram below it)
`timescale 1ns / 1ps
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser: command; tdata: x, y, value
// m_*       out  m_tvalid/m_tready  tdata: cell_now, cell_next
// apb       in   psel/penable/pwrite board_width @ 0x0, board_height @ 0x4
//
// a read and a write run through these steps from accept to result:
//   restoring steps reduce x and y modulo the board size, one restoring step each,
//   the rows above, at and below y load through the one ram read port,
//   a write then stores its row, and last the result loads into the output register
// a step reduces as well, then every row of the board is read as three rows and
//   written to the other bank, row after row, before its result loads as for a read
// reset clears control, flips back to bank zero and clears the one valid bit per
//   row at once, so no clearing pass; sizes return to 64 by 64
// the output register holds a result while m_tready is low; a new item is
//   accepted meanwhile but its result waits until the register is free
//
module toroidal_life_board_core
  import tlb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // x [5:0], y [11:6], value [12], zero pad
  input  logic [1:0]  s_tuser,   // command [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // cell_now [0], cell_next [1], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     cell_now, cell_next;

  // configuration registers; the user must write them only while the block is idle, which it does not enforce
  tlb_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // sequencer: one item at a time
  tlb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .stat    (dp_stat),
    .cmd     (dp_cmd)
  );

  // row registers, 64 life lanes, two banks in one ram, output register
  tlb_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_command   (s_tuser),
    .in_x         (s_tdata[5:0]),
    .in_y         (s_tdata[11:6]),
    .in_value     (s_tdata[12]),
    .cfg          (cfg),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_cell_now (cell_now),
    .out_cell_next(cell_next)
  );

  assign m_tdata = {6'b0, cell_next, cell_now};

  // an accepted item holds off the next one
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in progress");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.load_result |-> !(m_tvalid && !m_tready))
    else $error("result loaded into a full output register");

  // the bank flips only with the write of the last row of a sweep
  a_flip_at_end: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.flip_bank |-> dp_cmd.wr_step && (dp_cmd.sweep_row == ROW_LAST))
    else $error("bank flipped outside the end of a sweep");

  // sizes stay in range after any write
  a_dims_range: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> (cfg.board_width >= DIM_W'(2))
      && (cfg.board_width <= DIM_W'(MAX_WIDTH)) && (cfg.board_height >= DIM_W'(2))
      && (cfg.board_height <= DIM_W'(MAX_HEIGHT)))
    else $error("board size out of range");

endmodule

// ===== tb/toroidal_life_board_core_tb.sv =====
// self-checking bench for toroidal_life_board_core: stream commands, apb resizes
// depends on tlb_pkg and the rtl under hdl; a scoreboard class predicts every result
`timescale 1ns / 1ps

module toroidal_life_board_core_tb;
  import tlb_pkg::*;

  localparam int BANK_CELLS = MAX_WIDTH * MAX_HEIGHT;

  // command three has no name in the package; the block treats it as a read
  localparam cmd_t CMD_SPARE = 2'd3;

  // what one read, write or step should answer, with the item that caused it
  typedef struct packed {
    cmd_t       cmd;
    logic [5:0] x;
    logic [5:0] y;
    logic       now_bit;
    logic       next_bit;
  } cell_expect_t;

  // two-bank board predictor plus the queue of answers still owed
  class life_scoreboard;
    bit           cells [2][BANK_CELLS];
    bit           active;
    int unsigned  width;
    int unsigned  height;
    cell_expect_t owed_q[$];
    int unsigned  fail_count;
    int unsigned  n_write;
    int unsigned  n_read;
    int unsigned  n_step;
    int unsigned  n_spare;

    function new();
      for (int b = 0; b < 2; b++)
        for (int k = 0; k < BANK_CELLS; k++) cells[b][k] = 1'b0;
      active = 1'b0;
      width  = RESET_DIM;
      height = RESET_DIM;
    endfunction

    task report(string msg);
      if (fail_count < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
      fail_count++;
    endtask

    // register writes clamp into 2..64
    function void set_dim(logic reg_idx, int unsigned value);
      int unsigned hi;
      int unsigned v;
      hi = (reg_idx == REG_WIDTH) ? MAX_WIDTH : MAX_HEIGHT;
      v = (value < 2) ? 2 : ((value > hi) ? hi : value);
      if (reg_idx == REG_WIDTH) width = v;
      else height = v;
    endfunction

    function bit cell_at(bit b, int unsigned cx, int unsigned cy);
      return cells[b][(cy * MAX_WIDTH + cx) % BANK_CELLS];
    endfunction

    // neighbors wrap at the board size; on a size of 2 the same cell counts twice
    function bit next_of(bit b, int unsigned cx, int unsigned cy);
      int unsigned xs[3];
      int unsigned ys[3];
      int unsigned live_nb;
      live_nb = 0;
      xs[0] = (cx == 0) ? width - 1 : cx - 1;
      xs[1] = cx;
      xs[2] = (cx + 1 >= width) ? 0 : cx + 1;
      ys[0] = (cy == 0) ? height - 1 : cy - 1;
      ys[1] = cy;
      ys[2] = (cy + 1 >= height) ? 0 : cy + 1;
      for (int j = 0; j < 3; j++)
        for (int i = 0; i < 3; i++)
          if (i != 1 || j != 1) live_nb += cell_at(b, xs[i], ys[j]);
      return (live_nb == 3) || (live_nb == 2 && cell_at(b, cx, cy));
    endfunction

    // cells outside the area in use ride along unchanged into the new bank
    function void advance();
      bit dst;
      dst = !active;
      for (int k = 0; k < BANK_CELLS; k++) cells[dst][k] = cells[active][k];
      for (int cy = 0; cy < height; cy++)
        for (int cx = 0; cx < width; cx++)
          cells[dst][cy * MAX_WIDTH + cx] = next_of(active, cx, cy);
      active = dst;
    endfunction

    function void note_input(cmd_t cmd, logic [5:0] xi, logic [5:0] yi, logic val);
      cell_expect_t e;
      int unsigned  cx;
      int unsigned  cy;
      cx = xi % width;
      cy = yi % height;
      case (cmd)
        CMD_WRITE: begin
          cells[active][cy * MAX_WIDTH + cx] = val;
          n_write++;
        end
        CMD_STEP: begin
          advance();
          n_step++;
        end
        CMD_READ: n_read++;
        default:  n_spare++;
      endcase
      e.cmd      = cmd;
      e.x        = xi;
      e.y        = yi;
      e.now_bit  = cell_at(active, cx, cy);
      e.next_bit = next_of(active, cx, cy);
      owed_q.push_back(e);
    endfunction

    task check_result(logic [7:0] data);
      cell_expect_t e;
      if (owed_q.size() == 0) begin
        report($sformatf("result %h with nothing owed", data));
        return;
      end
      e = owed_q.pop_front();
      if (data[0] !== e.now_bit)
        report($sformatf("cmd %0d x %0d y %0d: cell_now %b, want %b",
                         e.cmd, e.x, e.y, data[0], e.now_bit));
      if (data[1] !== e.next_bit)
        report($sformatf("cmd %0d x %0d y %0d: cell_next %b, want %b",
                         e.cmd, e.x, e.y, data[1], e.next_bit));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // x [5:0], y [11:6], value [12], zero pad
  logic [1:0]  s_tuser = '0;   // command [1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // cell_now [0], cell_next [1], zero pad
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  life_scoreboard sb = new();

  // when set, neither side idles: the long back-to-back stretch
  bit          no_gaps = 1'b0;
  int unsigned n_sizes = 0;

  logic        res_take;
  logic [7:0]  res_data;

  toroidal_life_board_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls about a third of the cycles
  always @(posedge clk) begin
    m_tready <= no_gaps || ($urandom_range(0, 99) >= 34);
  end

  // outputs and inputs only move at the rising edge, so the value seen at the
  // falling edge is what the next rising edge sees
  always begin
    @(negedge clk);
    res_take = m_tvalid && m_tready && !rst;
    res_data = m_tdata;
    @(posedge clk);
    if (res_take) sb.check_result(res_data);
  end

  // one command item; valid stays high into the next item unless a gap is drawn
  task automatic send_item(cmd_t cmd, logic [5:0] cx, logic [5:0] cy, logic val);
    logic ok;
    if (!no_gaps && $urandom_range(0, 99) < 34) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 34);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, val, cy, cx};
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    sb.note_input(cmd, cx, cy, val);
  endtask

  // stop sending and let every owed result come back before touching registers
  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.owed_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.owed_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.owed_q.size()));
  endtask

  // apb write: setup phase, then access phase until pready
  task automatic write_dim(logic reg_idx, int unsigned value);
    logic ok;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ok = pready;
      @(posedge clk);
    end while (!ok);
    sb.set_dim(reg_idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic resize(int unsigned w, int unsigned h);
    wait_drained();
    write_dim(REG_WIDTH, w);
    write_dim(REG_HEIGHT, h);
    n_sizes++;
  endtask

  // mostly in-area writes and reads with some steps; the rest are command three
  // and coordinates past the wrap point, which the block reduces modulo the size
  task automatic random_phase(int n);
    int         kind;
    logic [5:0] rx;
    logic [5:0] ry;
    logic       v;
    cmd_t       c;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      rx = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, sb.width - 1))
                                         : 6'($urandom_range(0, 63));
      ry = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, sb.height - 1))
                                         : 6'($urandom_range(0, 63));
      v  = ($urandom_range(0, 99) < 45);
      if (kind < 14)      c = CMD_STEP;
      else if (kind < 20) c = CMD_SPARE;
      else if (kind < 62) c = CMD_WRITE;
      else                c = CMD_READ;
      send_item(c, rx, ry, v);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full 64 by 64 board straight out of reset
    send_item(CMD_READ, 6'd0, 6'd0, 1'b0);       // cleared store
    send_item(CMD_WRITE, 6'd63, 6'd0, 1'b1);     // blinker across the x wrap
    send_item(CMD_WRITE, 6'd0, 6'd0, 1'b1);
    send_item(CMD_WRITE, 6'd1, 6'd0, 1'b1);
    send_item(CMD_WRITE, 6'd63, 6'd63, 1'b1);    // far corner set, then cleared
    send_item(CMD_WRITE, 6'd63, 6'd63, 1'b0);
    send_item(CMD_READ, 6'd0, 6'd63, 1'b1);      // birth across the y wrap
    send_item(CMD_STEP, 6'd0, 6'd0, 1'b0);
    send_item(CMD_READ, 6'd0, 6'd63, 1'b0);
    send_item(CMD_SPARE, 6'd0, 6'd1, 1'b1);
    send_item(CMD_READ, 6'd63, 6'd63, 1'b1);
    send_item(CMD_STEP, 6'd63, 6'd63, 1'b1);     // blinker back to horizontal
    send_item(CMD_WRITE, 6'd40, 6'd62, 1'b1);    // lies outside the small boards
    n_sizes++;

    // below the low limit: clamps to 2 by 2, where neighbors repeat
    resize(0, 1);
    send_item(CMD_WRITE, 6'd63, 6'd63, 1'b1);    // reduces to 1,1
    send_item(CMD_WRITE, 6'd0, 6'd1, 1'b1);
    send_item(CMD_READ, 6'd1, 6'd0, 1'b0);
    send_item(CMD_STEP, 6'd2, 6'd3, 1'b0);
    send_item(CMD_READ, 6'd0, 6'd0, 1'b0);

    // above the high limit: back to 64 by 64, old cells reappear as left
    resize(127, 65);
    send_item(CMD_READ, 6'd1, 6'd0, 1'b0);
    send_item(CMD_READ, 6'd63, 6'd0, 1'b0);
    send_item(CMD_STEP, 6'd0, 6'd0, 1'b0);
    send_item(CMD_READ, 6'd40, 6'd62, 1'b0);

    // random phases over a spread of board shapes
    resize(5, 7);
    random_phase(19);
    resize(2, 3);
    random_phase(19);
    resize(64, 3);
    random_phase(19);
    resize(3, 64);
    random_phase(19);
    resize(6, 5);
    no_gaps = 1'b1;
    random_phase(24);
    wait_drained();
    no_gaps = 1'b0;
    resize(64, 64);
    random_phase(18);

    // drain, then give any stray late result time to show up
    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.owed_q.size() != 0)
      sb.report($sformatf("%0d results still owed at the end", sb.owed_q.size()));

    $display("run covered %0d writes, %0d reads, %0d steps, %0d command-three items",
             sb.n_write, sb.n_read, sb.n_step, sb.n_spare);
    $display("across %0d board sizes, clamped extremes included", n_sizes);
    if (sb.fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== toroidal_life_board_core.f =====
hdl/tlb_pkg.sv
hdl/tlb_ram.sv
hdl/tlb_cfg.sv
hdl/tlb_ctrl.sv
hdl/tlb_datapath.sv
hdl/toroidal_life_board_core.sv
tb/toroidal_life_board_core_tb.sv
